// ----- rtl/vrs_pkg.sv -----
// Shared types and constants for the voltage readout serializer.
`timescale 1ns / 1ps

package vrs_pkg;

    localparam int SAMPLE_W = 8;
    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 4;

    // floor(100*v/51) == (v * SCALE_MUL) >> SCALE_SHIFT for every 8-bit v
    localparam int SCALE_SHIFT = 20;
    localparam int SCALE_MUL   = 2056100;
    localparam int PROD_W      = 29;
    localparam int HUND_W      = 9;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_V     = 8'h76;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    localparam int LINE_LEN = 13;
    localparam int POS_W    = 4;

    typedef struct packed {
        logic [DIGIT_W-1:0] units;
        logic [DIGIT_W-1:0] tenths;
        logic [DIGIT_W-1:0] hund;
    } t_digits;

endpackage

// ----- rtl/vrs_digitizer.sv -----
// Scale one converter sample to hundredths of a volt and split it into digits.
`timescale 1ns / 1ps

module vrs_digitizer
    import vrs_pkg::*;
(
    input  logic [SAMPLE_W-1:0] i_sample,
    output t_digits             o_digits
);

    logic [PROD_W-1:0]  prod;
    logic [HUND_W-1:0]  h;
    logic [HUND_W-1:0]  rem_h;
    logic [6:0]         rem_t;
    logic [DIGIT_W-1:0] units;
    logic [DIGIT_W-1:0] tenths;

    assign prod = PROD_W'(i_sample) * PROD_W'(SCALE_MUL);
    assign h    = prod[PROD_W-1:SCALE_SHIFT];

    // units: largest k with h >= 100*k
    always_comb begin
        units = '0;
        for (int k = 1; k <= 5; k++) begin
            if (h >= HUND_W'(k * 100)) begin
                units = DIGIT_W'(k);
            end
        end
    end

    assign rem_h = h - HUND_W'(units * 7'd100);
    assign rem_t = rem_h[6:0];

    always_comb begin
        tenths = '0;
        for (int k = 1; k <= 9; k++) begin
            if (rem_t >= 7'(k * 10)) begin
                tenths = DIGIT_W'(k);
            end
        end
    end

    assign o_digits.units  = units;
    assign o_digits.tenths = tenths;
    assign o_digits.hund   = DIGIT_W'(rem_t - 7'(tenths * 4'd10));

endmodule

// ----- rtl/vrs_serializer.sv -----
// Character sequencer that walks one report line out per loaded sample pair.
`timescale 1ns / 1ps

module vrs_serializer
    import vrs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load_valid,
    output logic              o_load_ready,
    input  t_digits           i_first,
    input  t_digits           i_second,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CHAR_W-1:0] o_char,
    output logic              o_last
);

    localparam logic [POS_W-1:0] POS_U1    = 4'd0;
    localparam logic [POS_W-1:0] POS_DOT1  = 4'd1;
    localparam logic [POS_W-1:0] POS_T1    = 4'd2;
    localparam logic [POS_W-1:0] POS_H1    = 4'd3;
    localparam logic [POS_W-1:0] POS_V1    = 4'd4;
    localparam logic [POS_W-1:0] POS_COMMA = 4'd5;
    localparam logic [POS_W-1:0] POS_SPACE = 4'd6;
    localparam logic [POS_W-1:0] POS_U2    = 4'd7;
    localparam logic [POS_W-1:0] POS_DOT2  = 4'd8;
    localparam logic [POS_W-1:0] POS_T2    = 4'd9;
    localparam logic [POS_W-1:0] POS_H2    = 4'd10;
    localparam logic [POS_W-1:0] POS_V2    = 4'd11;
    localparam logic [POS_W-1:0] POS_CR    = POS_W'(LINE_LEN - 1);

    logic             r_busy, n_busy;
    logic [POS_W-1:0] r_pos, n_pos;
    t_digits          r_first, r_second;
    logic             take;
    logic             load;

    assign take         = r_busy && i_ready;
    assign o_load_ready = !r_busy || (take && r_pos == POS_CR);
    assign load         = i_load_valid && o_load_ready;

    always_comb begin
        n_busy = r_busy;
        n_pos  = r_pos;
        if (load) begin
            n_busy = 1'b1;
            n_pos  = POS_U1;
        end else if (take) begin
            if (r_pos == POS_CR) begin
                n_busy = 1'b0;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= POS_U1;
        end else begin
            r_busy <= n_busy;
            r_pos  <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_first  <= i_first;
            r_second <= i_second;
        end
    end

    always_comb begin
        unique case (r_pos)
            POS_U1:    o_char = CH_ZERO + CHAR_W'(r_first.units);
            POS_DOT1:  o_char = CH_DOT;
            POS_T1:    o_char = CH_ZERO + CHAR_W'(r_first.tenths);
            POS_H1:    o_char = CH_ZERO + CHAR_W'(r_first.hund);
            POS_V1:    o_char = CH_V;
            POS_COMMA: o_char = CH_COMMA;
            POS_SPACE: o_char = CH_SPACE;
            POS_U2:    o_char = CH_ZERO + CHAR_W'(r_second.units);
            POS_DOT2:  o_char = CH_DOT;
            POS_T2:    o_char = CH_ZERO + CHAR_W'(r_second.tenths);
            POS_H2:    o_char = CH_ZERO + CHAR_W'(r_second.hund);
            POS_V2:    o_char = CH_V;
            POS_CR:    o_char = CH_CR;
            default:   o_char = CH_CR;
        endcase
    end

    assign o_valid = r_busy;
    assign o_last  = (r_pos == POS_CR);

endmodule

// ----- rtl/voltage_readout_serializer_core.sv -----
// Top level of the voltage readout serializer: digit register and line sequencer.
`timescale 1ns / 1ps

// Usage
//   Input channel (i_in_valid / o_in_ready) carries one transaction per pair of
//   8-bit converter samples. Output channel (o_out_valid / i_out_ready) carries
//   one ASCII character per transaction, 13 per pair:
//     U '.' T H 'v' ',' ' ' U '.' T H 'v' CR
//   with o_last_char high on the closing carriage return. Each sample reads as
//   floor(100*v/51) hundredths of a volt.
// Start-up: with the sequencer idle, an accepted pair is first registered in the
//   digit register, which then loads the sequencer; the sequencer then offers
//   the first character of the line.
// Pacing: set by the single character port of the sequencer, which advances
//   only when i_out_ready takes a character. One pair waits in the digit
//   register while a line drains; the next follows the CR without a gap.
// Reset: i_rst_n low on a clock edge empties both stages; no output is offered.
// Stall: with i_out_ready low the current character holds; once the digit
//   register is full, o_in_ready drops until the sequencer takes its contents.
module voltage_readout_serializer_core
    import vrs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [SAMPLE_W-1:0] i_sample_one,
    input  logic [SAMPLE_W-1:0] i_sample_two,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [CHAR_W-1:0]   o_char_out,
    output logic                o_last_char
);

    t_digits digits_one, digits_two;
    t_digits r_digits_one, r_digits_two;
    logic    r_hold_valid, n_hold_valid;
    logic    seq_ready;
    logic    in_take;

    // Convert both samples straight off the input port
    vrs_digitizer u_dig_one (
        .i_sample (i_sample_one),
        .o_digits (digits_one)
    );

    vrs_digitizer u_dig_two (
        .i_sample (i_sample_two),
        .o_digits (digits_two)
    );

    // Digit register: accept when empty or when the sequencer drains it now
    assign o_in_ready = !r_hold_valid || seq_ready;
    assign in_take    = i_in_valid && o_in_ready;

    always_comb begin
        n_hold_valid = r_hold_valid;
        if (in_take) begin
            n_hold_valid = 1'b1;
        end else if (seq_ready) begin
            n_hold_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
        end else begin
            r_hold_valid <= n_hold_valid;
        end
    end

    // Hold digits until the sequencer loads them
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_digits_one <= digits_one;
            r_digits_two <= digits_two;
        end
    end

    // Walk the line out one character per output transaction
    vrs_serializer u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_hold_valid),
        .o_load_ready (seq_ready),
        .i_first      (r_digits_one),
        .i_second     (r_digits_two),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_char       (o_char_out),
        .o_last       (o_last_char)
    );

endmodule
